/* src/lca_euler_sparse_table_core_defines.svh */
`ifndef LCA_EULER_SPARSE_TABLE_CORE_DEFINES_SVH
`define LCA_EULER_SPARSE_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define LCA_EST_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LCA_EST_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/lca_est_pkg.sv */
package lca_est_pkg;

    localparam int VERT_W     = 10;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 11;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 16;

    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_W-1:0] OP_BUILD = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_BUILT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    localparam logic CFG_ROOT  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    function automatic logic [4:0] floor_log2(input logic [31:0] x);
        logic [4:0] r;
        r = '0;
        for (int i = 1; i < 32; i++) begin
            if (x[i]) begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

/* src/lca_est_ram.sv */
module lca_est_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/lca_est_ram2r.sv */
module lca_est_ram2r #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_a_reg;
    logic [WIDTH-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_a_reg <= mem_reg[rd_addr_a];
        rd_b_reg <= mem_reg[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

/* src/lca_euler_sparse_table_core.sv */
// channel   dir  handshake             payload
// s_        in   s_tvalid / s_tready   tuser: op; tdata: first_vertex, second_vertex
// m_        out  m_tvalid / m_tready   tuser: status; tdata: ancestor
// cfg_      in   cfg_wr_en             cfg_index, cfg_wdata
//
// one item at a time; query: occurrence read, table read, min, result; add edge: write
// one half, read other head, write other half, result; a refused word goes to the result;
// clear: head sweep, result; build: visit-mark sweep, push (top, edge, visit), pop (top,
// pop) or skipped edge (top, edge), then read and write per table entry, check per level
// reset runs a sweep of all MAX_VERTICES adjacency heads before s_tready rises
// a stalled result sits in the output register while the next word is taken
module lca_euler_sparse_table_core
    import lca_est_pkg::*;
#(
    parameter int MAX_VERTICES = 1024
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // first_vertex, second_vertex
    input  logic [OP_W-1:0]      s_tuser,   // op
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // ancestor
    output logic [STATUS_W-1:0]  m_tuser,   // status
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [COUNT_W-1:0]   cfg_wdata
);

    localparam int VIW      = $clog2(MAX_VERTICES);
    localparam int EDGE_CAP = 2 * MAX_VERTICES;
    localparam int TOUR_CAP = 2 * MAX_VERTICES;
    localparam int EIW      = $clog2(EDGE_CAP);
    localparam int ECW      = $clog2(EDGE_CAP + 1);
    localparam int TW       = $clog2(TOUR_CAP);
    localparam int LENW     = $clog2(TOUR_CAP + 1);
    localparam int LEVELS   = TW + 1;
    localparam int LIW      = $clog2(LEVELS);
    localparam int LVW      = $clog2(LEVELS + 1);
    localparam int SPW      = $clog2(MAX_VERTICES + 1);
    localparam int TAB_DEPTH = LEVELS << TW;
    localparam int TAB_AW   = $clog2(TAB_DEPTH);
    localparam int PW       = VIW + VERT_W;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_CLR     = 5'd1;
    localparam logic [4:0] S_AE_WR0  = 5'd2;
    localparam logic [4:0] S_AE_RD1  = 5'd3;
    localparam logic [4:0] S_AE_WR1  = 5'd4;
    localparam logic [4:0] S_B_SWEEP = 5'd5;
    localparam logic [4:0] S_B_ROOT  = 5'd6;
    localparam logic [4:0] S_B_TOP   = 5'd7;
    localparam logic [4:0] S_B_EDGE  = 5'd8;
    localparam logic [4:0] S_B_VIS   = 5'd9;
    localparam logic [4:0] S_B_POP   = 5'd10;
    localparam logic [4:0] S_B_LVL   = 5'd11;
    localparam logic [4:0] S_T_RD    = 5'd12;
    localparam logic [4:0] S_T_WR    = 5'd13;
    localparam logic [4:0] S_Q_OCC   = 5'd14;
    localparam logic [4:0] S_Q_RD    = 5'd15;
    localparam logic [4:0] S_Q_TAB   = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    typedef struct packed {
        logic           valid;
        logic [EIW-1:0] idx;
    } head_t;

    typedef struct packed {
        logic [VERT_W-1:0] target;
        logic              more;
        logic [EIW-1:0]    next;
    } edge_t;

    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic              has;
        logic [EIW-1:0]    cursor;
    } frame_t;

    typedef struct packed {
        logic          seen;
        logic [TW-1:0] pos;
    } occ_t;

    logic [VERT_W-1:0] s_first;
    logic [VERT_W-1:0] s_second;
    assign s_first  = s_tdata[VERT_W-1:0];
    assign s_second = s_tdata[2*VERT_W-1:VERT_W];

    logic [4:0]           state_reg, state_next;
    logic [VERT_W-1:0]    root_reg;
    logic [COUNT_W-1:0]   vcount_reg;
    logic [VERT_W-1:0]    u_reg, u_next, v_reg, v_next, t_reg, t_next;
    logic [ECW-1:0]       ecnt_reg, ecnt_next;
    logic                 built_reg, built_next;
    logic                 clr_emit_reg, clr_emit_next;
    logic [LENW-1:0]      len_reg, len_next;
    logic [SPW-1:0]       sp_reg, sp_next;
    frame_t               top_reg, top_next;
    logic [VIW-1:0]       cnt_reg, cnt_next;
    logic [LVW-1:0]       lvl_reg, lvl_next;
    logic [TW-1:0]        k_reg, k_next, l_reg, l_next, r_reg, r_next;
    logic [VERT_W-1:0]    res_anc_reg, res_anc_next;
    logic [STATUS_W-1:0]  res_st_reg, res_st_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VERT_W-1:0]    m_anc_reg, m_anc_next;
    logic [STATUS_W-1:0]  m_st_reg, m_st_next;

    logic               head_we;
    logic [VIW-1:0]     head_waddr, head_raddr;
    head_t              head_wdata, head_rdata;
    logic               edge_we;
    logic [EIW-1:0]     edge_waddr, edge_raddr;
    edge_t              edge_wdata, edge_rdata;
    logic               stack_we;
    logic [VIW-1:0]     stack_waddr, stack_raddr;
    frame_t             stack_wdata, stack_rdata;
    logic               occ_we;
    logic [VIW-1:0]     occ_waddr, occ_raddr_a, occ_raddr_b;
    occ_t               occ_wdata, occ_rdata_a, occ_rdata_b;
    logic               tab_we;
    logic [TAB_AW-1:0]  tab_waddr, tab_raddr_a, tab_raddr_b;
    logic [PW-1:0]      tab_wdata, tab_rdata_a, tab_rdata_b, tab_min;

    logic [TW+1:0]      lvl_span, lvl_half;
    logic [TW:0]        q_diff, q_span;
    logic [LIW-1:0]     q_lvl;

    function automatic logic in_range(input logic [VERT_W-1:0] x);
        return ({1'b0, x} < vcount_reg) && (32'(x) < MAX_VERTICES);
    endfunction

    lca_est_ram #(.WIDTH($bits(head_t)), .DEPTH(MAX_VERTICES)) u_head (
        .aclk(aclk), .wr_en(head_we), .wr_addr(head_waddr), .wr_data(head_wdata),
        .rd_addr(head_raddr), .rd_data(head_rdata)
    );

    lca_est_ram #(.WIDTH($bits(edge_t)), .DEPTH(EDGE_CAP)) u_edge (
        .aclk(aclk), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(edge_wdata),
        .rd_addr(edge_raddr), .rd_data(edge_rdata)
    );

    lca_est_ram #(.WIDTH($bits(frame_t)), .DEPTH(MAX_VERTICES)) u_stack (
        .aclk(aclk), .wr_en(stack_we), .wr_addr(stack_waddr), .wr_data(stack_wdata),
        .rd_addr(stack_raddr), .rd_data(stack_rdata)
    );

    lca_est_ram2r #(.WIDTH($bits(occ_t)), .DEPTH(MAX_VERTICES)) u_occ (
        .aclk(aclk), .wr_en(occ_we), .wr_addr(occ_waddr), .wr_data(occ_wdata),
        .rd_addr_a(occ_raddr_a), .rd_data_a(occ_rdata_a),
        .rd_addr_b(occ_raddr_b), .rd_data_b(occ_rdata_b)
    );

    lca_est_ram2r #(.WIDTH(PW), .DEPTH(TAB_DEPTH)) u_table (
        .aclk(aclk), .wr_en(tab_we), .wr_addr(tab_waddr), .wr_data(tab_wdata),
        .rd_addr_a(tab_raddr_a), .rd_data_a(tab_rdata_a),
        .rd_addr_b(tab_raddr_b), .rd_data_b(tab_rdata_b)
    );

    assign tab_min  = (tab_rdata_a < tab_rdata_b) ? tab_rdata_a : tab_rdata_b;
    assign lvl_span = (TW+2)'(1) << lvl_reg;
    assign lvl_half = lvl_span >> 1;
    assign q_diff   = (TW+1)'(r_reg) - (TW+1)'(l_reg) + (TW+1)'(1);
    assign q_lvl    = LIW'(floor_log2(32'(q_diff)));
    assign q_span   = (TW+1)'(1) << q_lvl;

    always_comb begin
        state_next    = state_reg;
        u_next        = u_reg;
        v_next        = v_reg;
        t_next        = t_reg;
        ecnt_next     = ecnt_reg;
        built_next    = built_reg;
        clr_emit_next = clr_emit_reg;
        len_next      = len_reg;
        sp_next       = sp_reg;
        top_next      = top_reg;
        cnt_next      = cnt_reg;
        lvl_next      = lvl_reg;
        k_next        = k_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        res_anc_next  = res_anc_reg;
        res_st_next   = res_st_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_anc_next    = m_anc_reg;
        m_st_next     = m_st_reg;

        head_we     = 1'b0;
        head_waddr  = '0;
        head_wdata  = '0;
        head_raddr  = '0;
        edge_we     = 1'b0;
        edge_waddr  = '0;
        edge_wdata  = '0;
        edge_raddr  = '0;
        stack_we    = 1'b0;
        stack_waddr = '0;
        stack_wdata = '0;
        stack_raddr = '0;
        occ_we      = 1'b0;
        occ_waddr   = '0;
        occ_wdata   = '0;
        occ_raddr_a = '0;
        occ_raddr_b = '0;
        tab_we      = 1'b0;
        tab_waddr   = '0;
        tab_wdata   = '0;
        tab_raddr_a = '0;
        tab_raddr_b = '0;

        case (state_reg)
            S_IDLE: begin
                head_raddr  = VIW'(s_first);
                occ_raddr_a = VIW'(s_first);
                occ_raddr_b = VIW'(s_second);
                if (s_tvalid) begin
                    u_next       = s_first;
                    v_next       = s_second;
                    res_anc_next = '0;
                    res_st_next  = ST_OK;
                    case (s_tuser)
                        OP_CLEAR: begin
                            ecnt_next     = '0;
                            built_next    = 1'b0;
                            cnt_next      = '0;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        OP_ADD: begin
                            if (!in_range(s_first) || !in_range(s_second)) begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end else if (32'(ecnt_reg) + 32'd2 > EDGE_CAP) begin
                                res_st_next = ST_FULL;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_AE_WR0;
                            end
                        end
                        OP_BUILD: begin
                            built_next = 1'b0;
                            if (!in_range(root_reg)) begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end else begin
                                cnt_next   = '0;
                                state_next = S_B_SWEEP;
                            end
                        end
                        default: begin
                            if (!built_reg) begin
                                res_st_next = ST_NOT_BUILT;
                                state_next  = S_DONE;
                            end else if (!in_range(s_first) || !in_range(s_second)) begin
                                res_st_next = ST_RANGE;
                                state_next  = S_DONE;
                            end else begin
                                state_next = S_Q_OCC;
                            end
                        end
                    endcase
                end
            end

            S_CLR: begin
                head_we    = 1'b1;
                head_waddr = cnt_reg;
                cnt_next   = cnt_reg + 1'b1;
                if (32'(cnt_reg) == MAX_VERTICES - 1) begin
                    state_next = clr_emit_reg ? S_DONE : S_IDLE;
                end
            end

            S_AE_WR0: begin
                edge_we           = 1'b1;
                edge_waddr        = EIW'(ecnt_reg);
                edge_wdata.target = v_reg;
                edge_wdata.more   = head_rdata.valid;
                edge_wdata.next   = head_rdata.idx;
                head_we           = 1'b1;
                head_waddr        = VIW'(u_reg);
                head_wdata.valid  = 1'b1;
                head_wdata.idx    = EIW'(ecnt_reg);
                ecnt_next         = ecnt_reg + 1'b1;
                state_next        = S_AE_RD1;
            end

            S_AE_RD1: begin
                head_raddr = VIW'(v_reg);
                state_next = S_AE_WR1;
            end

            S_AE_WR1: begin
                edge_we           = 1'b1;
                edge_waddr        = EIW'(ecnt_reg);
                edge_wdata.target = u_reg;
                edge_wdata.more   = head_rdata.valid;
                edge_wdata.next   = head_rdata.idx;
                head_we           = 1'b1;
                head_waddr        = VIW'(v_reg);
                head_wdata.valid  = 1'b1;
                head_wdata.idx    = EIW'(ecnt_reg);
                ecnt_next         = ecnt_reg + 1'b1;
                built_next        = 1'b0;
                state_next        = S_DONE;
            end

            S_B_SWEEP: begin
                occ_we     = 1'b1;
                occ_waddr  = cnt_reg;
                cnt_next   = cnt_reg + 1'b1;
                head_raddr = VIW'(root_reg);
                if (32'(cnt_reg) == MAX_VERTICES - 1) begin
                    state_next = S_B_ROOT;
                end
            end

            S_B_ROOT: begin
                occ_we          = 1'b1;
                occ_waddr       = VIW'(root_reg);
                occ_wdata.seen  = 1'b1;
                occ_wdata.pos   = '0;
                tab_we          = 1'b1;
                tab_waddr       = '0;
                tab_wdata       = {VIW'(0), root_reg};
                top_next.vertex = root_reg;
                top_next.has    = head_rdata.valid;
                top_next.cursor = head_rdata.idx;
                sp_next         = SPW'(1);
                len_next        = LENW'(1);
                state_next      = S_B_TOP;
            end

            S_B_TOP: begin
                edge_raddr  = top_reg.cursor;
                stack_raddr = VIW'(sp_reg - SPW'(2));
                if (top_reg.has) begin
                    state_next = S_B_EDGE;
                end else begin
                    sp_next = sp_reg - 1'b1;
                    if (sp_reg == SPW'(1)) begin
                        lvl_next   = LVW'(1);
                        state_next = S_B_LVL;
                    end else begin
                        state_next = S_B_POP;
                    end
                end
            end

            S_B_EDGE: begin
                top_next.has    = edge_rdata.more;
                top_next.cursor = edge_rdata.next;
                t_next          = edge_rdata.target;
                occ_raddr_a     = VIW'(edge_rdata.target);
                head_raddr      = VIW'(edge_rdata.target);
                if (in_range(edge_rdata.target) && 32'(sp_reg) < MAX_VERTICES) begin
                    state_next = S_B_VIS;
                end else begin
                    state_next = S_B_TOP;
                end
            end

            S_B_VIS: begin
                if (!occ_rdata_a.seen) begin
                    occ_we          = 1'b1;
                    occ_waddr       = VIW'(t_reg);
                    occ_wdata.seen  = 1'b1;
                    occ_wdata.pos   = TW'(len_reg);
                    tab_we          = 1'b1;
                    tab_waddr       = {LIW'(0), TW'(len_reg)};
                    tab_wdata       = {VIW'(sp_reg), t_reg};
                    len_next        = len_reg + 1'b1;
                    stack_we        = 1'b1;
                    stack_waddr     = VIW'(sp_reg - 1'b1);
                    stack_wdata     = top_reg;
                    top_next.vertex = t_reg;
                    top_next.has    = head_rdata.valid;
                    top_next.cursor = head_rdata.idx;
                    sp_next         = sp_reg + 1'b1;
                end
                state_next = S_B_TOP;
            end

            S_B_POP: begin
                top_next = stack_rdata;
                if (32'(len_reg) < TOUR_CAP) begin
                    tab_we    = 1'b1;
                    tab_waddr = {LIW'(0), TW'(len_reg)};
                    tab_wdata = {VIW'(sp_reg - 1'b1), stack_rdata.vertex};
                    len_next  = len_reg + 1'b1;
                end
                state_next = S_B_TOP;
            end

            S_B_LVL: begin
                k_next = '0;
                if (32'(lvl_reg) < LEVELS && lvl_span <= (TW+2)'(len_reg)) begin
                    state_next = S_T_RD;
                end else begin
                    built_next  = 1'b1;
                    res_st_next = ST_OK;
                    state_next  = S_DONE;
                end
            end

            S_T_RD: begin
                tab_raddr_a = {LIW'(lvl_reg - 1'b1), k_reg};
                tab_raddr_b = {LIW'(lvl_reg - 1'b1), TW'((TW+2)'(k_reg) + lvl_half)};
                if ((TW+2)'(k_reg) + lvl_span <= (TW+2)'(len_reg)) begin
                    state_next = S_T_WR;
                end else begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_B_LVL;
                end
            end

            S_T_WR: begin
                tab_we     = 1'b1;
                tab_waddr  = {LIW'(lvl_reg), k_reg};
                tab_wdata  = tab_min;
                k_next     = k_reg + 1'b1;
                state_next = S_T_RD;
            end

            S_Q_OCC: begin
                if (!occ_rdata_a.seen || !occ_rdata_b.seen) begin
                    res_st_next = ST_RANGE;
                    state_next  = S_DONE;
                end else if (u_reg == v_reg) begin
                    res_anc_next = u_reg;
                    state_next   = S_DONE;
                end else begin
                    if (occ_rdata_a.pos > occ_rdata_b.pos) begin
                        l_next = occ_rdata_b.pos;
                        r_next = occ_rdata_a.pos;
                    end else begin
                        l_next = occ_rdata_a.pos;
                        r_next = occ_rdata_b.pos;
                    end
                    state_next = S_Q_RD;
                end
            end

            S_Q_RD: begin
                tab_raddr_a = {q_lvl, l_reg};
                tab_raddr_b = {q_lvl, TW'((TW+1)'(r_reg) + (TW+1)'(1) - q_span)};
                state_next  = S_Q_TAB;
            end

            S_Q_TAB: begin
                res_anc_next = tab_min[VERT_W-1:0];
                state_next   = S_DONE;
            end

            S_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_anc_next   = res_anc_reg;
                    m_st_next    = res_st_reg;
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            root_reg     <= '0;
            vcount_reg   <= COUNT_W'(1024);
            ecnt_reg     <= '0;
            built_reg    <= 1'b0;
            clr_emit_reg <= 1'b0;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            ecnt_reg     <= ecnt_next;
            built_reg    <= built_next;
            clr_emit_reg <= clr_emit_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ROOT:  root_reg   <= cfg_wdata[VERT_W-1:0];
                    CFG_COUNT: vcount_reg <= cfg_wdata;
                    default:   root_reg   <= root_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        u_reg       <= u_next;
        v_reg       <= v_next;
        t_reg       <= t_next;
        len_reg     <= len_next;
        sp_reg      <= sp_next;
        top_reg     <= top_next;
        lvl_reg     <= lvl_next;
        k_reg       <= k_next;
        l_reg       <= l_next;
        r_reg       <= r_next;
        res_anc_reg <= res_anc_next;
        res_st_reg  <= res_st_next;
        m_anc_reg   <= m_anc_next;
        m_st_reg    <= m_st_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_TDATA_W - VERT_W)'(0), m_anc_reg};
    assign m_tuser  = m_st_reg;

endmodule

/* src/lca_est_checker.sv */
`include "lca_euler_sparse_table_core_defines.svh"

module lca_est_checker
    import lca_est_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,   // first_vertex, second_vertex
    input logic [OP_W-1:0]      s_tuser,   // op
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,   // ancestor
    input logic [STATUS_W-1:0]  m_tuser    // status
);

    `LCA_EST_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result word changed while stalled")
    `LCA_EST_ASSERT_NOW(a_err_zero, aclk, aresetn, m_tvalid && (m_tuser != ST_OK), m_tdata == '0, "ancestor not zero on error status")
    `LCA_EST_ASSERT_NOW(a_pad_zero, aclk, aresetn, m_tvalid, m_tdata[M_TDATA_W-1:VERT_W] == '0, "padding bits set in result word")
    `LCA_EST_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready, "second word taken while one is in work")

endmodule

bind lca_euler_sparse_table_core lca_est_checker u_lca_est_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

/* sim/lca_euler_sparse_table_core_tb.sv */
`timescale 1ns / 100ps

module lca_euler_sparse_table_core_tb;
    import lca_est_pkg::*;

    localparam int MAXV   = 1024;
    localparam int ECAP   = 2 * MAXV;
    localparam int LVLS   = 18;
    localparam int LIMIT  = 3000000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VERT_W-1:0] u;
        logic [VERT_W-1:0] v;
    } word_t;

    typedef struct packed {
        logic [VERT_W-1:0]   anc;
        logic [STATUS_W-1:0] st;
    } answer_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0]      s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic                 cfg_index = 1'b0;
    logic [COUNT_W-1:0]   cfg_wdata = '0;

    lca_euler_sparse_table_core #(.MAX_VERTICES(MAXV)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predictor state
    int unsigned adj_head [MAXV];
    bit          head_ok  [MAXV];
    int unsigned e_tgt    [ECAP];
    int unsigned e_nxt    [ECAP];
    bit          nxt_ok   [ECAP];
    int unsigned e_cnt;
    int unsigned stk_vtx  [MAXV];
    int unsigned stk_cur  [MAXV];
    bit          stk_has  [MAXV];
    int unsigned first_pos[MAXV];
    bit          seen     [MAXV];
    int unsigned rmq      [LVLS][ECAP];
    int unsigned tour_len;
    bit          built;
    int unsigned root_reg  = 0;
    int unsigned count_reg = 1024;

    word_t   pending_q[$];
    answer_t answer_q[$];
    word_t   cur_word;
    int      send_gap = 0;
    int      recv_hold = 0;
    bit      idle_on = 1'b1;
    bit      long_req = 1'b0;
    bit      long_done = 1'b0;
    int      mismatches = 0;
    int      cycles = 0;

    function automatic int unsigned usable();
        return (count_reg > MAXV) ? MAXV : count_reg;
    endfunction

    function automatic void wipe_store();
        for (int i = 0; i < MAXV; i++) begin
            head_ok[i] = 0;
            adj_head[i] = 0;
        end
        e_cnt = 0;
        built = 0;
    endfunction

    function automatic void link_edge(int unsigned from, int unsigned to);
        e_tgt[e_cnt] = to;
        e_nxt[e_cnt] = adj_head[from];
        nxt_ok[e_cnt] = head_ok[from];
        adj_head[from] = e_cnt;
        head_ok[from] = 1;
        e_cnt++;
    endfunction

    function automatic logic [STATUS_W-1:0] walk_tree();
        int unsigned n, len, sp, e, t, half;
        n = usable();
        len = 0;
        built = 0;
        for (int i = 0; i < MAXV; i++) seen[i] = 0;
        if (root_reg >= n) return ST_RANGE;
        seen[root_reg] = 1;
        first_pos[root_reg] = 0;
        rmq[0][len++] = root_reg;
        stk_vtx[0] = root_reg;
        stk_cur[0] = adj_head[root_reg];
        stk_has[0] = head_ok[root_reg];
        sp = 1;
        while (sp > 0) begin
            if (stk_has[sp-1]) begin
                e = stk_cur[sp-1];
                t = e_tgt[e];
                stk_has[sp-1] = nxt_ok[e];
                stk_cur[sp-1] = e_nxt[e];
                if (t < n && !seen[t] && sp < MAXV) begin
                    seen[t] = 1;
                    first_pos[t] = len;
                    rmq[0][len++] = (sp << 16) | t;
                    stk_vtx[sp] = t;
                    stk_cur[sp] = adj_head[t];
                    stk_has[sp] = head_ok[t];
                    sp++;
                end
            end else begin
                sp--;
                if (sp > 0 && len < ECAP)
                    rmq[0][len++] = ((sp - 1) << 16) | stk_vtx[sp-1];
            end
        end
        for (int i = 1; i < LVLS && (1 << i) <= len; i++) begin
            half = 1 << (i - 1);
            for (int k = 0; k + (1 << i) <= len; k++)
                rmq[i][k] = (rmq[i-1][k] < rmq[i-1][k+half]) ? rmq[i-1][k] : rmq[i-1][k+half];
        end
        tour_len = len;
        built = 1;
        return ST_OK;
    endfunction

    function automatic answer_t predict_answer(word_t w);
        answer_t a;
        int unsigned n, l, r, e, x, p, q;
        n = usable();
        a.anc = '0;
        a.st = ST_OK;
        case (w.op)
            OP_CLEAR: wipe_store();
            OP_ADD: begin
                if (w.u >= n || w.v >= n) a.st = ST_RANGE;
                else if (e_cnt + 2 > ECAP) a.st = ST_FULL;
                else begin
                    link_edge(w.u, w.v);
                    link_edge(w.v, w.u);
                    built = 0;
                end
            end
            OP_BUILD: a.st = walk_tree();
            default: begin
                if (!built) a.st = ST_NOT_BUILT;
                else if (w.u >= n || w.v >= n || !seen[w.u] || !seen[w.v]) a.st = ST_RANGE;
                else if (w.u == w.v) a.anc = w.u;
                else begin
                    l = first_pos[w.u];
                    r = first_pos[w.v];
                    if (l > r) begin
                        x = l; l = r; r = x;
                    end
                    x = r - l + 1;
                    e = 0;
                    while (x > 1) begin
                        x >>= 1;
                        e++;
                    end
                    if (e >= LVLS) e = LVLS - 1;
                    p = rmq[e][l];
                    q = rmq[e][r + 1 - (1 << e)];
                    a.anc = VERT_W'(((p < q) ? p : q) & 16'hFFFF);
                end
            end
        endcase
        return a;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                answer_q = {answer_q, predict_answer(cur_word)};
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (pending_q.size() > 0) begin
                    cur_word = pending_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser <= cur_word.op;
                    s_tdata <= {4'b0, cur_word.v, cur_word.u};
                    if (idle_on && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 13);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        answer_t exp_a;
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (answer_q.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("unexpected word: tdata %h tuser %0d", m_tdata, m_tuser);
                end else begin
                    exp_a = answer_q.pop_front();
                    if (m_tdata !== M_TDATA_W'(exp_a.anc) || m_tuser !== exp_a.st) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display("mismatch: expected anc %0d st %0d, got tdata %h st %0d",
                                     exp_a.anc, exp_a.st, m_tdata, m_tuser);
                    end
                end
            end
            if (long_req && !long_done) begin
                long_done = 1'b1;
                recv_hold = 3000;
                m_tready <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold = recv_hold - 1;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                recv_hold = $urandom_range(0, 12);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic put(logic [OP_W-1:0] op, int unsigned u, int unsigned v);
        word_t w;
        w.op = op;
        w.u = VERT_W'(u);
        w.v = VERT_W'(v);
        pending_q = {pending_q, w};
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || s_tvalid || answer_q.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= COUNT_W'(val);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == CFG_ROOT) root_reg = val & 10'h3FF;
        else count_reg = val & 11'h7FF;
    endtask

    // clear, random tree containing the root when it is in range, some noise, build, queries
    task automatic tree_phase(int unsigned cnt, int unsigned root, int unsigned m,
                              bit path, int unsigned nq);
        int unsigned n, a, b;
        int unsigned verts[$];
        bit taken[MAXV];
        n = (cnt > MAXV) ? MAXV : cnt;
        write_reg(CFG_COUNT, cnt);
        write_reg(CFG_ROOT, root);
        for (int i = 0; i < MAXV; i++) taken[i] = 0;
        if (m > n) m = n;
        if (root < n) begin
            verts = {verts, root};
            taken[root] = 1;
        end
        while (verts.size() < m) begin
            a = $urandom_range(0, n - 1);
            if (!taken[a]) begin
                taken[a] = 1;
                verts = {verts, a};
            end
        end
        put(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023));
        put(OP_QUERY, verts.size() ? verts[0] : 0, 0);
        for (int i = 1; i < verts.size(); i++) begin
            a = verts[i];
            b = path ? verts[i-1] : verts[$urandom_range(0, i - 1)];
            if ($urandom_range(0, 1)) put(OP_ADD, a, b);
            else put(OP_ADD, b, a);
            if ($urandom_range(0, 15) == 0) put(OP_ADD, a, b);
        end
        if (verts.size() > 0) put(OP_ADD, verts[0], verts[0]);
        put(OP_ADD, $urandom_range(0, 1023), $urandom_range(0, 1023));
        put(OP_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
        for (int i = 0; i < nq; i++) begin
            if (verts.size() > 0 && $urandom_range(0, 7) != 0) begin
                a = verts[$urandom_range(0, verts.size() - 1)];
                b = ($urandom_range(0, 9) == 0) ? a : verts[$urandom_range(0, verts.size() - 1)];
            end else begin
                a = $urandom_range(0, 1023);
                b = $urandom_range(0, 1023);
            end
            put(OP_QUERY, a, b);
        end
        if (n >= 2) begin
            put(OP_ADD, 0, 1);
            put(OP_QUERY, 0, 1);
            put(OP_BUILD, 0, 0);
            put(OP_QUERY, 0, 1);
        end
        drain();
    endtask

    initial begin
        int unsigned n;
        wipe_store();
        for (int i = 0; i < MAXV; i++) seen[i] = 0;
        tour_len = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed
        write_reg(CFG_ROOT, 0);
        write_reg(CFG_COUNT, 1024);
        put(OP_QUERY, 0, 1023);
        put(OP_BUILD, 0, 0);
        put(OP_QUERY, 0, 0);
        put(OP_QUERY, 0, 1);
        put(OP_ADD, 1023, 0);
        put(OP_QUERY, 0, 1023);
        put(OP_ADD, 0, 1);
        put(OP_ADD, 1, 1023);
        put(OP_ADD, 1023, 1023);
        put(OP_BUILD, 1023, 1023);
        put(OP_QUERY, 1023, 0);
        put(OP_QUERY, 1, 0);
        put(OP_QUERY, 1023, 1023);
        put(OP_QUERY, 512, 0);
        drain();
        write_reg(CFG_ROOT, 1023);
        put(OP_BUILD, 0, 0);
        put(OP_QUERY, 0, 1);
        drain();
        write_reg(CFG_COUNT, 1);
        drain();
        write_reg(CFG_ROOT, 0);
        put(OP_ADD, 0, 1);
        put(OP_ADD, 0, 0);
        put(OP_BUILD, 0, 0);
        put(OP_QUERY, 0, 0);
        put(OP_QUERY, 1, 0);
        put(OP_CLEAR, 1023, 1023);
        put(OP_QUERY, 0, 0);
        drain();

        // edge store fills up
        write_reg(CFG_COUNT, 8);
        write_reg(CFG_ROOT, 3);
        for (int i = 0; i < 1030; i++) put(OP_ADD, $urandom_range(0, 7), $urandom_range(0, 7));
        put(OP_BUILD, 0, 0);
        for (int i = 0; i < 20; i++) put(OP_QUERY, $urandom_range(0, 7), $urandom_range(0, 7));
        put(OP_CLEAR, 0, 0);
        put(OP_ADD, 2, 5);
        drain();

        // random trees under various settings
        tree_phase(2047, 1023, 30, 0, 20);
        long_req = 1'b1;
        tree_phase(40, 7, 40, 0, 30);
        tree_phase(16, 15, 16, 1, 30);
        tree_phase(2, 1, 2, 0, 15);
        tree_phase(1024, $urandom_range(0, 1023), 50, 0, 20);
        tree_phase(64, 63, 64, 1, 30);
        tree_phase(20, 25, 10, 0, 15);
        for (int p = 0; p < 3; p++) begin
            if (p >= 1) idle_on = 1'b0;
            n = $urandom_range(1, 100);
            tree_phase(n, $urandom_range(0, n - 1), $urandom_range(1, 60),
                       $urandom_range(0, 3) == 0, 40);
        end

        drain();
        repeat (200) @(posedge aclk);
        if (mismatches == 0 && answer_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
